FILE: rtl/bps_pkg.sv
// package: types, constants and register indexes of the battery power supervisor
`timescale 1ns / 1ps

package bps_pkg;

	localparam int unsigned PCT_W   = 7;
	localparam int unsigned MV_W    = 15;
	localparam int unsigned SEC_W   = 8;
	localparam int unsigned IN_W    = 32;
	localparam int unsigned OUT_W   = 24;
	localparam int unsigned CFG_W   = 15;
	localparam int unsigned CIDX_W  = 2;

	localparam logic [PCT_W-1:0] FULL_PCT        = 7'd100;
	localparam logic [MV_W-1:0]  RST_VBUS_LOW_MV = 15'd4000;
	localparam logic [SEC_W-1:0] RST_TIMEOUT_S   = 8'd90;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_VBUS_LOW_MV  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_SHOW_LOW_WARN = 2'd1;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT_S    = 2'd2;

	// prompt answers
	localparam logic [1:0] ANS_NONE   = 2'd0;
	localparam logic [1:0] ANS_OK     = 2'd1;
	localparam logic [1:0] ANS_HIDE   = 2'd2;
	localparam logic [1:0] ANS_CANCEL = 2'd3;

	// charge events
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_START   = 2'd1;
	localparam logic [1:0] EV_FULL    = 2'd2;
	localparam logic [1:0] EV_STOP    = 2'd3;

	typedef enum logic [2:0] {
		CS_NOT_CHARGING = 3'b001,
		CS_CHARGING     = 3'b010,
		CS_CHARGED      = 3'b100
	} charge_state_t;

	typedef struct packed {
		logic [MV_W-1:0]  vbus_low_mv;
		logic             show_low_warning;
		logic [SEC_W-1:0] poweroff_timeout_s;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       user_answer;
		logic [MV_W-1:0]  vbus_mv;
		logic             shutdown_req;
		logic [PCT_W-1:0] charge_pct;
		logic             charge_done;
		logic             chg_on;
		logic             gauge_ok;
	} item_t;

	typedef struct packed {
		logic             power_off_cmd;
		logic [SEC_W-1:0] time_left;
		logic             time_left_valid;
		logic             warning_hide;
		logic             warning_show;
		logic             refresh_icon;
		logic [PCT_W-1:0] level_pct;
		logic             level_changed;
		logic [1:0]       charge_event;
	} result_t;

	typedef struct packed {
		charge_state_t    charge_state;
		logic             low_batt;
		logic [SEC_W-1:0] countdown;
		logic [PCT_W-1:0] reported_level;
		logic [PCT_W-1:0] prev_charge;
		logic             prev_charging;
	} sup_state_t;

endpackage

FILE: rtl/battery_power_supervisor_top.sv
// top level: battery power supervisor with stream ports and config write port
//
// channel   direction  handshake         payload
// s_*       in         tvalid/tready     tdata: one poll tick sample
// m_*       out        tvalid/tready     tdata: one tick result
// cfg_*     in         cfg_we            cfg_index, cfg_wdata
//
// one item per cycle sustained while results are taken; an item is registered
// in the input register and then lands in the result register.
// the supervisor state is updated as the item moves into the result register.
// a stalled result holds the result register; the input register still takes
// one more item, then s_tready drops until the result is taken.
// arst_n clears state to its power-on values and config to its defaults.
`timescale 1ns / 1ps

module battery_power_supervisor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// gauge_ok, chg_on, charge_done, charge_pct[6:0], shutdown_req,
	// vbus_mv[14:0], user_answer[1:0], zero pad
	input  logic [bps_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// charge_event[1:0], level_changed, level_pct[6:0], refresh_icon,
	// warning_show, warning_hide, time_left_valid, time_left[7:0],
	// power_off_cmd, zero pad
	output logic [bps_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [bps_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [bps_pkg::CFG_W-1:0]      cfg_wdata
);
	import bps_pkg::*;

	cfg_t       cfg_q;
	item_t      item_s1;
	logic       valid_s1;
	sup_state_t state_q;
	sup_state_t state_nxt;
	result_t    res_comb;
	result_t    res_s2;
	logic       valid_s2;
	logic       advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vbus_low_mv        <= RST_VBUS_LOW_MV;
			cfg_q.show_low_warning   <= 1'b1;
			cfg_q.poweroff_timeout_s <= RST_TIMEOUT_S;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VBUS_LOW_MV:   cfg_q.vbus_low_mv        <= cfg_wdata;
				REG_SHOW_LOW_WARN: cfg_q.show_low_warning   <= cfg_wdata[0];
				REG_TIMEOUT_S:     cfg_q.poweroff_timeout_s <= cfg_wdata[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		end
	end

	bps_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.charge_state   <= CS_NOT_CHARGING;
			state_q.low_batt       <= 1'b0;
			state_q.countdown      <= RST_TIMEOUT_S;
			state_q.reported_level <= '0;
			state_q.prev_charge    <= '0;
			state_q.prev_charging  <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, res_s2};

`ifndef ASSERT_OFF
	a_tl_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.time_left_valid |-> res_s2.time_left != '0)
		else $error("time left shown as zero");

	a_tl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_s2.time_left_valid |-> res_s2.time_left == '0)
		else $error("time left not cleared when not valid");

	a_poff_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_s2.power_off_cmd && res_s2.time_left_valid))
		else $error("power-off together with a countdown value");

	a_cs_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.charge_state))
		else $error("charging state not one-hot");

	a_level_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> state_q.reported_level == res_s2.level_pct)
		else $error("reported level and result level disagree");
`endif

endmodule

FILE: rtl/bps_step.sv
// module: next-state and result logic for one poll tick
`timescale 1ns / 1ps

module bps_step (
	input  bps_pkg::cfg_t       cfg,
	input  bps_pkg::item_t      item,
	input  bps_pkg::sup_state_t cur,
	output bps_pkg::sup_state_t nxt,
	output bps_pkg::result_t    res
);
	import bps_pkg::*;

	logic             low_now;
	logic             low_after;
	logic [SEC_W-1:0] cd_mid;

	always_comb begin
		nxt = cur;
		res = '0;

		res.refresh_icon = (item.charge_pct != cur.prev_charge) ||
			(item.chg_on != cur.prev_charging);
		nxt.prev_charge   = item.charge_pct;
		nxt.prev_charging = item.chg_on;

		// low battery check and power-off countdown
		low_now = item.shutdown_req && (item.vbus_mv < cfg.vbus_low_mv) &&
			cfg.show_low_warning;
		low_after = cur.low_batt;
		cd_mid    = cur.countdown;
		if (item.gauge_ok) begin
			low_after = low_now;
			if (low_now && !cur.low_batt) begin
				res.warning_show = 1'b1;
			end
			if (!low_now && cur.low_batt) begin
				res.warning_hide = 1'b1;
				cd_mid = cfg.poweroff_timeout_s;
			end
		end
		nxt.low_batt  = low_after;
		nxt.countdown = cd_mid;
		if (item.gauge_ok && low_after) begin
			case (item.user_answer)
				ANS_OK: begin
					res.power_off_cmd = 1'b1;
				end
				ANS_CANCEL: begin
					res.warning_hide = 1'b1;
				end
				default: begin
					if (item.user_answer == ANS_HIDE) begin
						res.warning_hide = 1'b1;
					end
					if (cd_mid != '0) begin
						res.time_left_valid = 1'b1;
						res.time_left       = cd_mid;
						nxt.countdown       = cd_mid - 1'b1;
					end else begin
						res.power_off_cmd = 1'b1;
					end
				end
			endcase
		end

		// charging machine
		res.charge_event = EV_NONE;
		if (item.chg_on) begin
			if (item.charge_pct == FULL_PCT || item.charge_done) begin
				if (cur.charge_state != CS_CHARGED) begin
					nxt.charge_state = CS_CHARGED;
					res.charge_event = EV_FULL;
				end
			end else if (cur.charge_state != CS_CHARGING) begin
				nxt.charge_state = CS_CHARGING;
				res.charge_event = EV_START;
			end
		end else if (cur.charge_state != CS_NOT_CHARGING) begin
			nxt.charge_state = CS_NOT_CHARGING;
			res.charge_event = EV_STOP;
		end

		// level change
		res.level_changed  = (cur.reported_level != item.charge_pct);
		nxt.reported_level = item.charge_pct;
		res.level_pct      = item.charge_pct;
	end

endmodule
